### rtl/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and constants shared by the format spec parser modules.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // parser phase codes
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_FLAGS = 3'd1;
    localparam logic [2:0] PH_WIDTH = 3'd2;
    localparam logic [2:0] PH_PREC  = 3'd3;
    localparam logic [2:0] PH_MODS  = 3'd4;
    localparam logic [2:0] PH_SKIP  = 3'd5;

    // length modifier result codes
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_H     = 3'd1;
    localparam logic [2:0] LEN_HH    = 3'd2;
    localparam logic [2:0] LEN_L     = 3'd3;
    localparam logic [2:0] LEN_PAIR  = 3'd4;
    localparam logic [2:0] LEN_Z     = 3'd5;
    localparam logic [2:0] LEN_J     = 3'd6;

    // characters of interest
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_J       = 8'h6A;
    localparam logic [7:0] CH_Z       = 8'h7A;
    localparam logic [7:0] CH_L       = 8'h6C;

    localparam logic [1:0] MOD_COUNT_MAX = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_final;
    } fsp_in_t;

    typedef struct packed {
        logic        zero_pad;
        logic        left_justify;
        logic [15:0] min_width;
        logic        has_precision;
        logic [15:0] precision;
        logic [2:0]  length_code;
        logic [7:0]  conversion;
    } fsp_out_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        seen_zero;
        logic        seen_minus;
        logic [15:0] width_acc;
        logic        dot_seen;
        logic [15:0] prec_acc;
        logic [1:0]  mod_count;
        logic [7:0]  mod_first;
    } fsp_state_t;

endpackage

### rtl/fsp_digit_acc.sv
// ----------------------------------------------------------------------------
// fsp_digit_acc
// Decimal accumulator step: acc * 10 + digit, saturating at a limit.
// ----------------------------------------------------------------------------
module fsp_digit_acc #(
    parameter logic [15:0] ACC_MAX = 16'hFFFF
) (
    input  logic [15:0] acc,
    input  logic [7:0]  ch,
    output logic [15:0] acc_next
);

    logic [19:0] times_ten;
    logic [19:0] sum;
    logic [7:0]  digit;

    // times ten as two shifted adds
    assign times_ten = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    assign digit     = ch - fsp_pkg::CH_ZERO;
    assign sum       = times_ten + {16'd0, digit[3:0]};
    assign acc_next  = (sum > {4'd0, ACC_MAX}) ? ACC_MAX : sum[15:0];

endmodule

### rtl/fsp_parse_step.sv
// ----------------------------------------------------------------------------
// fsp_parse_step
// Next parser state and result for one character.
// ----------------------------------------------------------------------------
module fsp_parse_step #(
    parameter logic [15:0] ACC_MAX = 16'hFFFF
) (
    input  fsp_pkg::fsp_in_t    in_data,
    input  fsp_pkg::fsp_state_t state_cur,
    output fsp_pkg::fsp_state_t state_next,
    output fsp_pkg::fsp_out_t   result
);

    logic [15:0] width_step;
    logic [15:0] prec_step;
    logic        is_flag;
    logic        is_digit;
    logic        is_mod;
    logic [7:0]  c;

    assign c = in_data.ch;

    fsp_digit_acc #(.ACC_MAX(ACC_MAX)) u_width_acc (
        .acc      (state_cur.width_acc),
        .ch       (c),
        .acc_next (width_step)
    );

    fsp_digit_acc #(.ACC_MAX(ACC_MAX)) u_prec_acc (
        .acc      (state_cur.prec_acc),
        .ch       (c),
        .acc_next (prec_step)
    );

    assign is_flag  = (c == fsp_pkg::CH_MINUS) || (c == fsp_pkg::CH_ZERO)
                   || (c == fsp_pkg::CH_PLUS)  || (c == fsp_pkg::CH_SPACE)
                   || (c == fsp_pkg::CH_HASH)  || (c == fsp_pkg::CH_PERCENT);
    assign is_digit = (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
    assign is_mod   = (c == fsp_pkg::CH_H) || (c == fsp_pkg::CH_J)
                   || (c == fsp_pkg::CH_Z) || (c == fsp_pkg::CH_L);

    // result fields from the state before the final character
    always_comb begin
        result.zero_pad      = state_cur.seen_zero & ~state_cur.seen_minus;
        result.left_justify  = state_cur.seen_minus;
        result.min_width     = state_cur.width_acc;
        result.has_precision = state_cur.dot_seen;
        result.precision     = state_cur.prec_acc;
        result.conversion    = c;
        result.length_code   = fsp_pkg::LEN_NONE;
        if (state_cur.mod_count == 2'd2) begin
            result.length_code = (state_cur.mod_first == fsp_pkg::CH_H) ?
                                 fsp_pkg::LEN_HH : fsp_pkg::LEN_PAIR;
        end else if (state_cur.mod_count == 2'd1) begin
            priority if (state_cur.mod_first == fsp_pkg::CH_H) begin
                result.length_code = fsp_pkg::LEN_H;
            end else if (state_cur.mod_first == fsp_pkg::CH_L) begin
                result.length_code = fsp_pkg::LEN_L;
            end else if (state_cur.mod_first == fsp_pkg::CH_Z) begin
                result.length_code = fsp_pkg::LEN_Z;
            end else if (state_cur.mod_first == fsp_pkg::CH_J) begin
                result.length_code = fsp_pkg::LEN_J;
            end else begin
                result.length_code = fsp_pkg::LEN_NONE;
            end
        end
    end

    // phase walk, falling through to the next phase when a character does not fit
    always_comb begin
        logic       taken;
        logic [2:0] ph;
        state_next = state_cur;
        taken      = 1'b0;
        ph         = state_cur.phase;
        if (in_data.is_final) begin
            state_next           = '0;
            state_next.phase     = fsp_pkg::PH_START;
        end else if (ph == fsp_pkg::PH_START) begin
            state_next.phase = fsp_pkg::PH_FLAGS;
        end else begin
            if (ph == fsp_pkg::PH_FLAGS) begin
                if (is_flag) begin
                    taken = 1'b1;
                    if (c == fsp_pkg::CH_ZERO) state_next.seen_zero = 1'b1;
                    if (c == fsp_pkg::CH_MINUS) state_next.seen_minus = 1'b1;
                end else begin
                    ph = fsp_pkg::PH_WIDTH;
                end
            end
            if (!taken && ph == fsp_pkg::PH_WIDTH) begin
                if (is_digit) begin
                    taken = 1'b1;
                    state_next.width_acc = width_step;
                end else if (c == fsp_pkg::CH_DOT) begin
                    taken = 1'b1;
                    state_next.dot_seen = 1'b1;
                    ph = fsp_pkg::PH_PREC;
                end else begin
                    ph = fsp_pkg::PH_MODS;
                end
            end
            if (!taken && ph == fsp_pkg::PH_PREC) begin
                if (is_digit) begin
                    taken = 1'b1;
                    state_next.prec_acc = prec_step;
                end else begin
                    ph = fsp_pkg::PH_MODS;
                end
            end
            if (!taken && ph == fsp_pkg::PH_MODS) begin
                if (is_mod) begin
                    if (state_cur.mod_count == 2'd0) state_next.mod_first = c;
                    if (state_cur.mod_count != fsp_pkg::MOD_COUNT_MAX) begin
                        state_next.mod_count = state_cur.mod_count + 2'd1;
                    end
                end else begin
                    ph = fsp_pkg::PH_SKIP;
                end
            end
            state_next.phase = ph;
        end
    end

endmodule

### rtl/format_spec_parser_core.sv
// ----------------------------------------------------------------------------
// format_spec_parser_core
// Parses a printf conversion spec, one character per transfer.
// ----------------------------------------------------------------------------
// result path: the final character is held in the input register, then its
//   result in the result register, and m_valid rises once the result register
//   is loaded
// throughput: one character per cycle unless a final one waits for the result
//   slot; the phase update is one pass of logic from input register to parser state
// reset: synchronous active-low aresetn clears both valid flags and returns the
//   parser to the start phase with all flags and accumulators at zero
module format_spec_parser_core #(
    parameter int NUM_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fsp_pkg::fsp_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fsp_pkg::fsp_out_t  m_data
);

    // accumulator ceiling: all ones in NUM_BITS bits, never above the 16-bit field
    localparam int unsigned AccLim = (NUM_BITS >= 16) ? 32'd65535 :
                                     ((32'd1 << NUM_BITS) - 32'd1);
    localparam logic [15:0] ACC_MAX = 16'(AccLim);

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    fsp_pkg::fsp_in_t    in_data_reg;

    // parser state
    fsp_pkg::fsp_state_t state_reg;
    fsp_pkg::fsp_state_t state_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    fsp_pkg::fsp_out_t   out_data_reg;
    fsp_pkg::fsp_out_t   step_result;

    logic                out_free;
    logic                advance;

    // result slot can take a new result this cycle
    assign out_free = !out_valid_reg || m_ready;

    // non-final characters only touch the state; a final one needs the result slot
    assign advance = in_valid_reg && (!in_data_reg.is_final || out_free);

    // input register refills when empty or when its item moves on this cycle
    assign s_ready = !in_valid_reg || advance;

    fsp_parse_step #(.ACC_MAX(ACC_MAX)) u_step (
        .in_data    (in_data_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_data_reg.is_final) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: fsp_pkg::PH_START, default: '0};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && in_data_reg.is_final) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### rtl/fsp_checker.sv
// ----------------------------------------------------------------------------
// fsp_checker
// Port-level checks for the format spec parser, bound to the top level.
// ----------------------------------------------------------------------------
module fsp_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input fsp_pkg::fsp_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input fsp_pkg::fsp_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a stalled input transfer holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while stalled");

    a_pad_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.zero_pad && m_data.left_justify))
        else $error("zero pad with left justify");

    a_prec_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.precision != 16'd0) |-> m_data.has_precision)
        else $error("precision without dot");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind format_spec_parser_core fsp_checker u_fsp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
